// ----- rtl/spbs_pkg.sv -----
// Shared types, constants and the microcode program for the sorted pair
// binary search block. No dependencies.
`default_nettype none

package spbs_pkg;

    // Table geometry
    localparam int unsigned MaxPairs = 256;
    localparam int unsigned AddrW    = $clog2(MaxPairs);
    localparam int unsigned CntW     = AddrW + 1;
    localparam int unsigned ProbeW   = AddrW + 2;
    localparam int unsigned KeyW     = 16;
    localparam int unsigned ValW     = 16;
    localparam int unsigned EntryW   = KeyW + ValW;

    // Configuration port
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;
    localparam logic [ApbAddrW-3:0] REG_ENTRY_COUNT = '0;

    // Request function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Microcode step addresses
    localparam int unsigned StepW = 2;
    typedef logic [StepW-1:0] step_t;
    localparam step_t STEP_DISPATCH = 2'd0;
    localparam step_t STEP_SEARCH   = 2'd1;
    localparam step_t STEP_EMIT     = 2'd2;
    localparam step_t STEP_SPARE    = 2'd3;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_NO_QUERY,
        COND_MORE_PROBES,
        COND_OUT_BUSY
    } cond_t;

    // One microcode word
    typedef struct packed {
        logic  take_in;
        logic  search;
        logic  emit;
        cond_t cond;
        step_t jump_to;
        step_t fall_to;
    } uword_t;

    // Datapath controls from the sequencer
    typedef struct packed {
        logic take_in;
        logic search;
        logic emit;
    } dp_ctrl_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic query_go;
        logic more_probes;
        logic out_busy;
    } dp_stat_t;

    // Control store
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        case (step)
            STEP_DISPATCH: w = '{take_in: 1'b1, search: 1'b0, emit: 1'b0,
                                 cond: COND_NO_QUERY,
                                 jump_to: STEP_DISPATCH, fall_to: STEP_SEARCH};
            STEP_SEARCH:   w = '{take_in: 1'b0, search: 1'b1, emit: 1'b0,
                                 cond: COND_MORE_PROBES,
                                 jump_to: STEP_SEARCH, fall_to: STEP_EMIT};
            STEP_EMIT:     w = '{take_in: 1'b0, search: 1'b0, emit: 1'b1,
                                 cond: COND_OUT_BUSY,
                                 jump_to: STEP_EMIT, fall_to: STEP_DISPATCH};
            default:       w = '{take_in: 1'b0, search: 1'b0, emit: 1'b0,
                                 cond: COND_ALWAYS,
                                 jump_to: STEP_DISPATCH, fall_to: STEP_DISPATCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/spbs_if.sv -----
// Request and response channel interfaces for the sorted pair search block.
// Depends on spbs_pkg.
`default_nettype none

interface spbs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [spbs_pkg::KeyW-1:0]     key;
    logic [spbs_pkg::ValW-1:0]     value;
    logic [spbs_pkg::AddrW-1:0]    position;

    modport source (output valid, func, key, value, position, input ready);
    modport sink   (input valid, func, key, value, position, output ready);
endinterface

interface spbs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [spbs_pkg::ValW-1:0]     match_value;

    modport source (output valid, found, match_value, input ready);
    modport sink   (input valid, found, match_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/spbs_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on spbs_pkg.
`default_nettype none

module spbs_seq (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire spbs_pkg::dp_stat_t stat,
    output spbs_pkg::dp_ctrl_t  ctrl
);

    spbs_pkg::step_t  step_reg;
    spbs_pkg::step_t  step_next;
    spbs_pkg::uword_t uword;
    logic             taken;

    // Control word for the current step
    assign uword = spbs_pkg::ucode_rom(step_reg);

    assign ctrl.take_in = uword.take_in;
    assign ctrl.search  = uword.search;
    assign ctrl.emit    = uword.emit;

    // Jump condition select
    always_comb
    begin
        case (uword.cond)
            spbs_pkg::COND_ALWAYS:      taken = 1'b1;
            spbs_pkg::COND_NO_QUERY:    taken = !stat.query_go;
            spbs_pkg::COND_MORE_PROBES: taken = stat.more_probes;
            spbs_pkg::COND_OUT_BUSY:    taken = stat.out_busy;
            default:                    taken = 1'b1;
        endcase
    end

    assign step_next = taken ? uword.jump_to : uword.fall_to;

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= spbs_pkg::STEP_DISPATCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/spbs_dp.sv -----
// Search datapath: pair table memory, probe/span registers, key compare and
// the output register. Depends on spbs_pkg and the channel interfaces.
`default_nettype none

module spbs_dp (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire spbs_pkg::dp_ctrl_t          ctrl,
    input  wire [spbs_pkg::CntW-1:0]         entry_count,
    output spbs_pkg::dp_stat_t               stat,
    spbs_req_if.sink                         req_in,
    spbs_rsp_if.source                       rsp_out
);

    localparam int unsigned AddrW  = spbs_pkg::AddrW;
    localparam int unsigned CntW   = spbs_pkg::CntW;
    localparam int unsigned ProbeW = spbs_pkg::ProbeW;
    localparam int unsigned KeyW   = spbs_pkg::KeyW;
    localparam int unsigned ValW   = spbs_pkg::ValW;
    localparam int unsigned EntryW = spbs_pkg::EntryW;

    logic [EntryW-1:0] table_mem [spbs_pkg::MaxPairs];

    logic [EntryW-1:0] rd_data_reg;
    logic [KeyW-1:0]   key_reg;
    logic [CntW-1:0]   span_reg;
    logic [CntW-1:0]   span_next;
    logic [ProbeW-1:0] probe_reg;
    logic [ProbeW-1:0] probe_next;
    logic              found_reg;
    logic [ValW-1:0]   match_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_found_reg;
    logic [ValW-1:0]   out_value_reg;

    logic              load_acc;
    logic              query_acc;
    logic [CntW-1:0]   cnt_sat;
    logic [CntW-1:0]   span_init;
    logic [ProbeW-1:0] probe_init;
    logic [ProbeW-1:0] half_ext;
    logic [ProbeW-1:0] probe_step;
    logic [KeyW-1:0]   rd_key;
    logic              probe_neg;
    logic              hit;
    logic              less;
    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
    logic              out_busy;
    logic              out_load;

    // Request handshake
    assign req_in.ready = ctrl.take_in;
    assign load_acc  = ctrl.take_in && req_in.valid && (req_in.func == spbs_pkg::FUNC_LOAD);
    assign query_acc = ctrl.take_in && req_in.valid && (req_in.func == spbs_pkg::FUNC_QUERY);

    // Search setup: clamp count, top power of two, first probe
    assign cnt_sat = (entry_count > CntW'(spbs_pkg::MaxPairs))
                   ? CntW'(spbs_pkg::MaxPairs) : entry_count;

    always_comb
    begin
        span_init = '0;
        for (int i = 0; i < CntW; i++)
        begin
            if (cnt_sat[i])
            begin
                span_init    = '0;
                span_init[i] = 1'b1;
            end
        end
    end

    assign probe_init = {1'b0, cnt_sat & ~span_init};

    // Compare and next probe; a negative probe counts as below the key
    assign rd_key     = rd_data_reg[EntryW-1:ValW];
    assign probe_neg  = probe_reg[ProbeW-1];
    assign hit        = (span_reg != '0) && !probe_neg && (rd_key == key_reg);
    assign less       = probe_neg || (rd_key < key_reg);
    assign span_next  = span_reg >> 1;
    assign half_ext   = {1'b0, span_next};
    assign probe_step = less ? (probe_reg + half_ext) : (probe_reg - half_ext);

    // Table read port: first probe at dispatch, following probes while searching
    assign rd_en   = query_acc || ctrl.search;
    assign rd_addr = ctrl.search ? probe_step[AddrW-1:0] : probe_init[AddrW-1:0];

    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            table_mem[req_in.position] <= {req_in.key, req_in.value};
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Search registers
    assign probe_next = query_acc ? probe_init : probe_step;

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            key_reg   <= req_in.key;
            span_reg  <= span_init;
            probe_reg <= probe_next;
            found_reg <= 1'b0;
            match_reg <= '0;
        end
        else if (ctrl.search)
        begin
            span_reg  <= span_next;
            probe_reg <= probe_next;
            if (hit)
            begin
                found_reg <= 1'b1;
                match_reg <= rd_data_reg[ValW-1:0];
            end
        end
    end

    // Output register
    assign out_busy = out_valid_reg && !rsp_out.ready;
    assign out_load = ctrl.emit && !out_busy;

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= found_reg;
            out_value_reg <= match_reg;
        end
    end

    assign rsp_out.valid       = out_valid_reg;
    assign rsp_out.found       = out_found_reg;
    assign rsp_out.match_value = out_value_reg;

    // Status to the sequencer
    assign stat.query_go    = query_acc;
    assign stat.more_probes = (span_reg > CntW'(1)) && !hit;
    assign stat.out_busy    = out_busy;

endmodule

`default_nettype wire

// ----- rtl/sorted_pair_binary_search.sv -----
// Sorted pair binary search. A load request writes one (key, value) pair to
// a table slot. A query takes a dispatch step, then a search step per
// probe, floor(log2(count)) + 1 probes at most (fewer on an early match),
// then an emit step that loads the output register once it is free.
// The single-port table read feeds each compare-and-step. The table has no
// reset; slots must be loaded before a query can reach them. The user must
// see that entry_count (APB offset 0) is written only while idle; the block
// does not enforce it. Depends on spbs_pkg, spbs_if, spbs_seq and spbs_dp.
`default_nettype none

module sorted_pair_binary_search (
    input  wire                              clk,
    input  wire                              rst_n,
    spbs_req_if.sink                         req_in,
    spbs_rsp_if.source                       rsp_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [spbs_pkg::ApbAddrW-1:0]     paddr,
    input  wire [spbs_pkg::ApbDataW-1:0]     pwdata,
    output logic [spbs_pkg::ApbDataW-1:0]    prdata,
    output logic                             pready
);

    logic [spbs_pkg::CntW-1:0] entry_count_reg;
    logic [spbs_pkg::CntW-1:0] entry_count_next;
    logic                      cfg_sel;
    logic                      cfg_wr;
    spbs_pkg::dp_ctrl_t        ctrl;
    spbs_pkg::dp_stat_t        stat;

    // Register decode
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[spbs_pkg::ApbAddrW-1:2] == spbs_pkg::REG_ENTRY_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

    assign entry_count_next = cfg_wr ? pwdata[spbs_pkg::CntW-1:0] : entry_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    assign prdata = cfg_sel
                  ? {{(spbs_pkg::ApbDataW - spbs_pkg::CntW){1'b0}}, entry_count_reg}
                  : '0;

    // Sequencer
    spbs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Datapath
    spbs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .entry_count (entry_count_reg),
        .stat        (stat),
        .req_in      (req_in),
        .rsp_out     (rsp_out)
    );

endmodule

`default_nettype wire
